// ----- hdl/free_server_allocator_defines.svh -----
// Assertion macros shared by the allocator modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef FREE_SERVER_ALLOCATOR_DEFINES_SVH
`define FREE_SERVER_ALLOCATOR_DEFINES_SVH

// Checked on every rising edge outside reset.
`define FSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define FSA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/fsa_pkg.sv -----
package fsa_pkg;

  // Pool size and derived widths.
  localparam int unsigned MAX_SERVERS = 128;
  localparam int unsigned IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned CFG_W = 8;
  localparam int unsigned CNT_RAW_W = $clog2(MAX_SERVERS + 1);
  localparam int unsigned CNT_W = (CNT_RAW_W > CFG_W) ? CNT_RAW_W : CFG_W;

  // Field widths.
  localparam int unsigned TIME_W = 20;
  localparam int unsigned NEED_W = 8;
  localparam int unsigned DUR_W = 10;
  localparam int unsigned BUSY_W = 21;
  localparam int unsigned SUM_W = 14;

  localparam logic [CFG_W-1:0] SERVER_COUNT_RESET = 8'd128;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_ALLOC,
    ST_RESULT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_en;
    logic start_alloc;
    logic alloc_mode;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic enough;
  } sts_t;

endpackage

// ----- hdl/fsa_ctrl.sv -----
`include "free_server_allocator_defines.svh"

module fsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fsa_pkg::sts_t sts_i,
  output fsa_pkg::cmd_t cmd_o
);
  import fsa_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: count free servers, then allocate if there are enough.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_COUNT;
      end
      ST_COUNT: begin
        if (sts_i.scan_done) begin
          state_d = sts_i.enough ? ST_ALLOC : ST_RESULT;
        end
      end
      ST_ALLOC: begin
        if (sts_i.scan_done) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready_o        = 1'b0;
    out_valid_o       = 1'b0;
    cmd_o             = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_COUNT: begin
        cmd_o.scan_en     = 1'b1;
        cmd_o.start_alloc = sts_i.scan_done && sts_i.enough;
      end
      ST_ALLOC: begin
        cmd_o.scan_en    = 1'b1;
        cmd_o.alloc_mode = 1'b1;
      end
      ST_RESULT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  `FSA_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |=> (state_q == ST_IDLE), "not idle in reset")
  `FSA_ASSERT(a_result_after_scan, $rose(out_valid_o) |-> $past(sts_i.scan_done), "early result")
  `FSA_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")

endmodule

// ----- hdl/fsa_dp.sv -----
`include "free_server_allocator_defines.svh"

module fsa_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fsa_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [fsa_pkg::TIME_W-1:0]   arrival_time_i,
  input  logic [fsa_pkg::NEED_W-1:0]   servers_needed_i,
  input  logic [fsa_pkg::DUR_W-1:0]    duration_i,
  input  fsa_pkg::cmd_t                cmd_i,
  output fsa_pkg::sts_t                sts_o,
  output logic                         granted_o,
  output logic [fsa_pkg::SUM_W-1:0]    id_sum_o
);
  import fsa_pkg::*;

  logic [CFG_W-1:0]       server_count_q;
  logic [CNT_W-1:0]       count_ext;
  logic [CNT_W-1:0]       count_eff;
  logic [TIME_W-1:0]      arrival_q;
  logic [NEED_W-1:0]      need_q;
  logic [CNT_W-1:0]       need_ext;
  logic [BUSY_W-1:0]      end_q;
  logic [CNT_W-1:0]       pos_q;
  logic                   issue;
  logic [IDX_W-1:0]       rd_addr;
  logic [BUSY_W-1:0]      mem [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] valid_q;
  logic [BUSY_W-1:0]      rd_q;
  logic                   rdv_q;
  logic                   cmp_vld_q;
  logic [IDX_W-1:0]       cmp_idx_q;
  logic [BUSY_W-1:0]      busy_val;
  logic                   is_free;
  logic [CNT_W-1:0]       free_cnt_q;
  logic [CNT_W-1:0]       taken_q;
  logic                   mem_we;
  logic                   granted_q;
  logic [SUM_W-1:0]       sum_q;

  // Server count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_count_q <= SERVER_COUNT_RESET;
    end else if (cfg_we_i) begin
      server_count_q <= cfg_data_i;
    end
  end

  // Active servers, clipped to the pool size.
  assign count_ext = CNT_W'(server_count_q);
  assign count_eff = (count_ext > CNT_W'(MAX_SERVERS)) ? CNT_W'(MAX_SERVERS) : count_ext;
  assign need_ext  = CNT_W'(need_q);

  // Task latch; the end time is formed once at load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrival_q <= '0;
      need_q    <= '0;
      end_q     <= '0;
    end else if (cmd_i.load) begin
      arrival_q <= arrival_time_i;
      need_q    <= servers_needed_i;
      end_q     <= BUSY_W'(arrival_time_i) + BUSY_W'(duration_i);
    end
  end

  // Scan pointer: one read issued per cycle while inside the active range.
  assign issue   = cmd_i.scan_en && (pos_q < count_eff);
  assign rd_addr = pos_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= issue;
      if (cmd_i.load || cmd_i.start_alloc) begin
        pos_q <= '0;
      end else if (issue) begin
        pos_q <= pos_q + CNT_W'(1);
      end
    end
  end

  // Busy-until memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmp_idx_q] <= end_q;
    end
    rd_q      <= mem[rd_addr];
    rdv_q     <= valid_q[rd_addr];
    cmp_idx_q <= rd_addr;
  end

  // Entries never written read as zero, so every server starts free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[cmp_idx_q] <= 1'b1;
    end
  end

  // Compare stage.
  assign busy_val = rdv_q ? rd_q : '0;
  assign is_free  = busy_val <= BUSY_W'(arrival_q);
  assign mem_we   = cmp_vld_q && is_free && cmd_i.alloc_mode && (taken_q < need_ext);

  // Free count, taken count and result accumulation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_cnt_q <= '0;
      taken_q    <= '0;
      granted_q  <= 1'b0;
      sum_q      <= '0;
    end else if (cmd_i.load) begin
      free_cnt_q <= '0;
      taken_q    <= '0;
      granted_q  <= 1'b0;
      sum_q      <= '0;
    end else begin
      if (cmd_i.start_alloc) begin
        granted_q <= 1'b1;
      end
      if (cmp_vld_q && is_free && !cmd_i.alloc_mode) begin
        free_cnt_q <= free_cnt_q + CNT_W'(1);
      end
      if (mem_we) begin
        taken_q <= taken_q + CNT_W'(1);
        sum_q   <= sum_q + SUM_W'(CNT_W'(cmp_idx_q) + CNT_W'(1));
      end
    end
  end

  assign sts_o.scan_done = !issue && !cmp_vld_q;
  assign sts_o.enough    = free_cnt_q >= need_ext;
  assign granted_o       = granted_q;
  assign id_sum_o        = sum_q;

  `FSA_ASSERT(a_taken_bounded, taken_q <= need_ext, "more servers taken than needed")
  `FSA_ASSERT(a_sum_only_granted, (sum_q != '0) |-> granted_q, "id sum on refused task")
  `FSA_ASSERT(a_cmp_in_scan, cmp_vld_q |-> cmd_i.scan_en, "compare outside a scan")

endmodule

// ----- hdl/free_server_allocator.sv -----
// First-fit server allocator.
// Input channel (in_valid_i/in_ready_o) carries one task request: arrival
// time, number of servers needed and duration. Output channel
// (out_valid_o/out_ready_i) returns one result per request: a grant flag and
// the sum of the granted server ids (zero when refused).
// The server count register is written through cfg_we_i/cfg_data_i; the
// user must write it only while idle, as the block does not enforce this.
// One request is processed at a time. A counting pass reads each active
// server's busy-until entry from the memory, one entry per cycle through its
// single read port; a granted request then takes a second pass that claims the
// lowest-numbered free servers. The result follows the counting pass when
// refused and the claiming pass when granted.
// Reset marks every server free and sets the server count to 128; no
// clearing pass is needed. The result stays on the output until it is
// taken; while the receiver stalls, no new request is accepted.
module free_server_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fsa_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fsa_pkg::TIME_W-1:0]  arrival_time_i,
  input  logic [fsa_pkg::NEED_W-1:0]  servers_needed_i,
  input  logic [fsa_pkg::DUR_W-1:0]   duration_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        granted_o,
  output logic [fsa_pkg::SUM_W-1:0]   id_sum_o
);
  import fsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  fsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Busy-until store, scan and result registers.
  fsa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .arrival_time_i   (arrival_time_i),
    .servers_needed_i (servers_needed_i),
    .duration_i       (duration_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .granted_o        (granted_o),
    .id_sum_o         (id_sum_o)
  );

endmodule
